// ===== rtl/acit_pkg.sv =====
package acit_pkg;

    localparam int NUM_TIMERS = 3;
    localparam int NUM_PORTS  = 4;
    localparam int NUM_AUX    = 2;

    localparam logic [7:0] SLOW_TIMER_PERIOD = 8'd128;
    localparam logic [7:0] FAST_TIMER_PERIOD = 8'd16;

    localparam logic [2:0] CMD_REG_READ   = 3'd0;
    localparam logic [2:0] CMD_REG_WRITE  = 3'd1;
    localparam logic [2:0] CMD_TIMER_STEP = 3'd2;
    localparam logic [2:0] CMD_HOST_WRITE = 3'd3;
    localparam logic [2:0] CMD_HOST_READ  = 3'd4;

    localparam logic [3:0] REG_TEST    = 4'h0;
    localparam logic [3:0] REG_CONTROL = 4'h1;
    localparam logic [3:0] REG_DSPADDR = 4'h2;
    localparam logic [3:0] REG_DSPDATA = 4'h3;
    localparam logic [3:0] REG_PORT0   = 4'h4;
    localparam logic [3:0] REG_PORT1   = 4'h5;
    localparam logic [3:0] REG_PORT2   = 4'h6;
    localparam logic [3:0] REG_PORT3   = 4'h7;
    localparam logic [3:0] REG_AUX0    = 4'h8;
    localparam logic [3:0] REG_AUX1    = 4'h9;
    localparam logic [3:0] REG_TARGET0 = 4'hA;
    localparam logic [3:0] REG_TARGET1 = 4'hB;
    localparam logic [3:0] REG_TARGET2 = 4'hC;
    localparam logic [3:0] REG_OUT0    = 4'hD;
    localparam logic [3:0] REG_OUT1    = 4'hE;
    localparam logic [3:0] REG_OUT2    = 4'hF;

    // Per-beat strobes from the register decode to one timer.
    typedef struct packed {
        logic       step;
        logic [4:0] clocks;
        logic       regate;
        logic       gate_open;
        logic       ctl_write;
        logic       enable_bit;
        logic       target_write;
        logic       out_read;
        logic [7:0] data;
    } acit_tmr_ctl_t;

    // Control outputs as they stand after the current beat.
    typedef struct packed {
        logic [7:0] dsp_address;
        logic       ram_writable;
        logic       ram_disabled;
        logic       boot_rom_enabled;
        logic [1:0] external_wait;
        logic [1:0] internal_wait;
    } acit_status_t;

endpackage

// ===== rtl/acit_timer.sv =====
module acit_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            period,
    input  acit_pkg::acit_tmr_ctl_t ctl,
    output logic [3:0]            tick_out
);
    import acit_pkg::*;

    logic [7:0] prescale_reg, prescale_next;
    logic       toggle_reg, toggle_next;
    logic       level_reg, level_next;
    logic       enable_reg, enable_next;
    logic [7:0] count_reg, count_next;
    logic [3:0] out_reg, out_next;
    logic [7:0] target_reg, target_next;

    logic [8:0] acc;
    logic [8:0] acc_wrap;
    logic       do_gate;
    logic       lvl;
    logic       fall;
    logic [7:0] count_inc;

    assign tick_out  = out_reg;
    assign acc       = {1'b0, prescale_reg} + {4'b0, ctl.clocks};
    assign acc_wrap  = acc - {1'b0, period};
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        prescale_next = prescale_reg;
        toggle_next   = toggle_reg;
        enable_next   = enable_reg;
        count_next    = count_reg;
        out_next      = out_reg;
        target_next   = target_reg;
        do_gate       = ctl.regate;

        if (ctl.step)
        begin
            if (acc >= {1'b0, period})
            begin
                // The prescaler saturates rather than carrying a second wrap.
                prescale_next = acc_wrap[8] ? 8'hFF : acc_wrap[7:0];
                toggle_next   = ~toggle_reg;
                do_gate       = 1'b1;
            end
            else
            begin
                prescale_next = acc[7:0];
            end
        end

        lvl        = toggle_next & ctl.gate_open;
        fall       = do_gate & level_reg & ~lvl;
        level_next = do_gate ? lvl : level_reg;

        if (fall && enable_reg)
        begin
            if (count_inc == target_reg)
            begin
                count_next = 8'd0;
                out_next   = out_reg + 4'd1;
            end
            else
            begin
                count_next = count_inc;
            end
        end

        if (ctl.ctl_write)
        begin
            if (!enable_reg && ctl.enable_bit)
            begin
                count_next = 8'd0;
                out_next   = 4'd0;
            end
            enable_next = ctl.enable_bit;
        end

        if (ctl.target_write)
        begin
            target_next = ctl.data;
        end

        if (ctl.out_read)
        begin
            out_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 8'd0;
            toggle_reg   <= 1'b0;
            level_reg    <= 1'b0;
            enable_reg   <= 1'b0;
            count_reg    <= 8'd0;
            out_reg      <= 4'd0;
            target_reg   <= 8'd0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            toggle_reg   <= toggle_next;
            level_reg    <= level_next;
            enable_reg   <= enable_next;
            count_reg    <= count_next;
            out_reg      <= out_next;
            target_reg   <= target_next;
        end
    end

endmodule

// ===== rtl/acit_regs.sv =====
module acit_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic [2:0]              command,
    input  logic [3:0]              reg_index,
    input  logic [7:0]              write_data,
    input  logic [4:0]              timer_clocks,
    input  logic                    direct_page_flag,
    input  logic [7:0]              dsp_read_data,
    input  logic [3:0]              tick_out [acit_pkg::NUM_TIMERS],
    output acit_pkg::acit_tmr_ctl_t tmr_ctl [acit_pkg::NUM_TIMERS],
    output logic [7:0]              read_data,
    output logic                    dsp_write_valid,
    output acit_pkg::acit_status_t  status
);
    import acit_pkg::*;

    logic       halt_reg, halt_next;
    logic       ram_wr_reg, ram_wr_next;
    logic       ram_off_reg, ram_off_next;
    logic       run_reg, run_next;
    logic [1:0] ext_wait_reg, ext_wait_next;
    logic [1:0] int_wait_reg, int_wait_next;
    logic       boot_rom_reg, boot_rom_next;
    logic [7:0] dsp_addr_reg, dsp_addr_next;
    logic [7:0] to_host_reg [NUM_PORTS];
    logic [7:0] to_host_next [NUM_PORTS];
    logic [7:0] from_host_reg [NUM_PORTS];
    logic [7:0] from_host_next [NUM_PORTS];
    logic [7:0] aux_reg [NUM_AUX];
    logic [7:0] aux_next [NUM_AUX];

    logic       is_read;
    logic       is_write;
    logic       host_port_ok;

    assign is_read      = fire && (command == CMD_REG_READ);
    assign is_write     = fire && (command == CMD_REG_WRITE);
    assign host_port_ok = (reg_index[3:2] == 2'b00);

    always_comb
    begin
        halt_next      = halt_reg;
        ram_wr_next    = ram_wr_reg;
        ram_off_next   = ram_off_reg;
        run_next       = run_reg;
        ext_wait_next  = ext_wait_reg;
        int_wait_next  = int_wait_reg;
        boot_rom_next  = boot_rom_reg;
        dsp_addr_next  = dsp_addr_reg;
        to_host_next   = to_host_reg;
        from_host_next = from_host_reg;
        aux_next       = aux_reg;
        read_data      = 8'd0;
        dsp_write_valid = 1'b0;

        case (command)
            CMD_REG_READ:
            begin
                case (reg_index)
                    REG_DSPADDR: read_data = dsp_addr_reg;
                    REG_DSPDATA: read_data = dsp_read_data;
                    REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
                        read_data = from_host_reg[reg_index[1:0]];
                    REG_AUX0, REG_AUX1: read_data = aux_reg[reg_index[0]];
                    REG_OUT0: read_data = {4'd0, tick_out[0]};
                    REG_OUT1: read_data = {4'd0, tick_out[1]};
                    REG_OUT2: read_data = {4'd0, tick_out[2]};
                    default: read_data = 8'd0;
                endcase
            end
            CMD_REG_WRITE:
            begin
                case (reg_index)
                    REG_TEST:
                    begin
                        if (!direct_page_flag)
                        begin
                            halt_next     = write_data[0];
                            ram_wr_next   = write_data[1];
                            ram_off_next  = write_data[2];
                            run_next      = write_data[3];
                            ext_wait_next = write_data[5:4];
                            int_wait_next = write_data[7:6];
                        end
                    end
                    REG_CONTROL:
                    begin
                        if (write_data[4])
                        begin
                            from_host_next[0] = 8'd0;
                            from_host_next[1] = 8'd0;
                        end
                        if (write_data[5])
                        begin
                            from_host_next[2] = 8'd0;
                            from_host_next[3] = 8'd0;
                        end
                        boot_rom_next = write_data[7];
                    end
                    REG_DSPADDR: dsp_addr_next = write_data;
                    // DSP registers with address bit 7 set are read-only.
                    REG_DSPDATA: dsp_write_valid = ~dsp_addr_reg[7];
                    REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
                        to_host_next[reg_index[1:0]] = write_data;
                    REG_AUX0, REG_AUX1: aux_next[reg_index[0]] = write_data;
                    default: ;
                endcase
            end
            CMD_HOST_WRITE:
            begin
                if (host_port_ok)
                begin
                    from_host_next[reg_index[1:0]] = write_data;
                end
            end
            CMD_HOST_READ:
            begin
                if (host_port_ok)
                begin
                    read_data = to_host_reg[reg_index[1:0]];
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            tmr_ctl[t].step         = fire && (command == CMD_TIMER_STEP);
            tmr_ctl[t].clocks       = timer_clocks;
            tmr_ctl[t].regate       = is_write && (reg_index == REG_TEST) && !direct_page_flag;
            tmr_ctl[t].gate_open    = run_next & ~halt_next;
            tmr_ctl[t].ctl_write    = is_write && (reg_index == REG_CONTROL);
            tmr_ctl[t].enable_bit   = write_data[t];
            tmr_ctl[t].target_write = is_write && (reg_index == REG_TARGET0 + 4'(t));
            tmr_ctl[t].out_read     = is_read && (reg_index == REG_OUT0 + 4'(t));
            tmr_ctl[t].data         = write_data;
        end
    end

    assign status.dsp_address      = dsp_addr_next;
    assign status.ram_writable     = ram_wr_next;
    assign status.ram_disabled     = ram_off_next;
    assign status.boot_rom_enabled = boot_rom_next;
    assign status.external_wait    = ext_wait_next;
    assign status.internal_wait    = int_wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg     <= 1'b0;
            ram_wr_reg   <= 1'b1;
            ram_off_reg  <= 1'b0;
            run_reg      <= 1'b1;
            ext_wait_reg <= 2'd0;
            int_wait_reg <= 2'd0;
            boot_rom_reg <= 1'b1;
            dsp_addr_reg <= 8'd0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                to_host_reg[i]   <= 8'd0;
                from_host_reg[i] <= 8'd0;
            end
            for (int i = 0; i < NUM_AUX; i++)
            begin
                aux_reg[i] <= 8'd0;
            end
        end
        else if (fire)
        begin
            halt_reg      <= halt_next;
            ram_wr_reg    <= ram_wr_next;
            ram_off_reg   <= ram_off_next;
            run_reg       <= run_next;
            ext_wait_reg  <= ext_wait_next;
            int_wait_reg  <= int_wait_next;
            boot_rom_reg  <= boot_rom_next;
            dsp_addr_reg  <= dsp_addr_next;
            to_host_reg   <= to_host_next;
            from_host_reg <= from_host_next;
            aux_reg       <= aux_next;
        end
    end

endmodule

// ===== rtl/audio_cpu_io_timer_block_top.sv =====
// I/O register and timer block: sixteen registers at offsets 0xF0-0xFF, four host
// mailbox ports in each direction and three timers (0 and 1 divide the timer clock
// by 128, timer 2 by 16). Every beat gives exactly one result beat. An item is
// captured in an input register and, when the result side is not stalled, processed
// through one pass of decode and timer logic into the result register; one item is
// taken every cycle while the result side does not stall. The single input register
// lets a new beat in while a finished result waits under stall.
module audio_cpu_io_timer_block_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [2:0] command,
    input  logic [3:0] reg_index,
    input  logic [7:0] write_data,
    input  logic [4:0] timer_clocks,
    input  logic       direct_page_flag,
    input  logic [7:0] dsp_read_data,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] read_data,
    output logic       dsp_write_valid,
    output logic [7:0] dsp_address,
    output logic       ram_writable,
    output logic       ram_disabled,
    output logic       boot_rom_enabled,
    output logic [1:0] external_wait,
    output logic [1:0] internal_wait
);
    import acit_pkg::*;

    logic       item_vld_reg, item_vld_next;
    logic [2:0] cmd_reg;
    logic [3:0] idx_reg;
    logic [7:0] wdata_reg;
    logic [4:0] clocks_reg;
    logic       pflag_reg;
    logic [7:0] dsp_in_reg;

    logic       result_vld_reg, result_vld_next;
    logic [7:0] rdata_reg;
    logic       dsp_wr_reg;
    acit_status_t status_reg;

    logic         accept;
    logic         advance;
    logic         fire;
    logic [7:0]   rdata_comb;
    logic         dsp_wr_comb;
    acit_status_t status_comb;
    acit_tmr_ctl_t tmr_ctl [NUM_TIMERS];
    logic [3:0]   tick_out [NUM_TIMERS];
    logic [7:0]   tmr_period [NUM_TIMERS];

    assign advance    = !(result_vld_reg && result_stall);
    assign fire       = item_vld_reg && advance;
    assign item_stall = item_vld_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign item_vld_next   = accept ? 1'b1 : (advance ? 1'b0 : item_vld_reg);
    assign result_vld_next = fire ? 1'b1 : (result_stall ? result_vld_reg : 1'b0);

    assign tmr_period[0] = SLOW_TIMER_PERIOD;
    assign tmr_period[1] = SLOW_TIMER_PERIOD;
    assign tmr_period[2] = FAST_TIMER_PERIOD;

    acit_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .command          (cmd_reg),
        .reg_index        (idx_reg),
        .write_data       (wdata_reg),
        .timer_clocks     (clocks_reg),
        .direct_page_flag (pflag_reg),
        .dsp_read_data    (dsp_in_reg),
        .tick_out         (tick_out),
        .tmr_ctl          (tmr_ctl),
        .read_data        (rdata_comb),
        .dsp_write_valid  (dsp_wr_comb),
        .status           (status_comb)
    );

    for (genvar t = 0; t < NUM_TIMERS; t++)
    begin : g_timer
        acit_timer u_timer (
            .clk      (clk),
            .rst_n    (rst_n),
            .period   (tmr_period[t]),
            .ctl      (tmr_ctl[t]),
            .tick_out (tick_out[t])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg   <= item_vld_next;
            result_vld_reg <= result_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            idx_reg    <= reg_index;
            wdata_reg  <= write_data;
            clocks_reg <= timer_clocks;
            pflag_reg  <= direct_page_flag;
            dsp_in_reg <= dsp_read_data;
        end
        if (fire)
        begin
            rdata_reg  <= rdata_comb;
            dsp_wr_reg <= dsp_wr_comb;
            status_reg <= status_comb;
        end
    end

    assign result_valid     = result_vld_reg;
    assign read_data        = rdata_reg;
    assign dsp_write_valid  = dsp_wr_reg;
    assign dsp_address      = status_reg.dsp_address;
    assign ram_writable     = status_reg.ram_writable;
    assign ram_disabled     = status_reg.ram_disabled;
    assign boot_rom_enabled = status_reg.boot_rom_enabled;
    assign external_wait    = status_reg.external_wait;
    assign internal_wait    = status_reg.internal_wait;

    // A beat that leaves the input register always lands in the result register.
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_vld_reg)
        else $error("processed beat did not reach the result register");

    // A held beat is never dropped while the result side stalls.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_vld_reg && !advance |=> item_vld_reg)
        else $error("stalled input beat was lost");

    // A DSP write is a write command, so it never carries read data.
    a_dsp_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_vld_reg && dsp_wr_reg |-> rdata_reg == 8'd0)
        else $error("DSP write beat carries read data");

endmodule
